@@ hw/rtl/indexed_lcd_controller_with_vram_top_macros.svh @@
// assertion macros for the indexed lcd controller
`ifndef INDEXED_LCD_CONTROLLER_WITH_VRAM_TOP_MACROS_SVH
`define INDEXED_LCD_CONTROLLER_WITH_VRAM_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ILCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcd controller check failed");
`define ILCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcd controller check failed");
`else
`define ILCD_ASSERT_IMP(label, ante, cons)
`define ILCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/ilcd_pkg.sv @@
// shared constants, codes and helpers for the indexed lcd controller
package ilcd_pkg;

  localparam int unsigned VRAM_DEPTH_DEF = 4096;
  localparam int unsigned VADDR_W        = 14;

  // request kinds
  localparam logic [1:0] KIND_INDEX = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // register map
  localparam logic [7:0] REG_CTRL1 = 8'd0;
  localparam logic [7:0] REG_CTRL2 = 8'd1;
  localparam logic [7:0] REG_WCOL  = 8'd2;
  localparam logic [7:0] REG_WROW  = 8'd3;
  localparam logic [7:0] REG_MEM   = 8'd4;
  localparam logic [7:0] REG_PAL0  = 8'd12;
  localparam logic [7:0] REG_PAL1  = 8'd13;
  localparam logic [7:0] REG_PAL2  = 8'd14;
  localparam logic [7:0] REG_PAL3  = 8'd15;

  localparam logic [VADDR_W-1:0] MEM_LIMIT  = VADDR_W'(4000);
  localparam logic [VADDR_W-1:0] LINE_BYTES = VADDR_W'(40);
  localparam logic [8:0]         WIDE_WRAP   = 9'h036;
  localparam logic [8:0]         NARROW_WRAP = 9'h028;
  localparam logic [7:0]         GRAY_STEP   = 8'd85;
  localparam logic [7:0]         FULL        = 8'hFF;
  localparam logic [7:0]         COL_MAX     = 8'd159;
  localparam logic [6:0]         ROW_MAX     = 7'd99;

  // reciprocals scaled by 2^13, exact for dividends up to 256
  localparam logic [7:0] RECIP_WIDE   = 8'd152;
  localparam logic [7:0] RECIP_NARROW = 8'd205;

  typedef logic [7:0] pal_t [4];
  localparam pal_t PAL_INIT = '{8'h00, 8'h0B, 8'h17, 8'h1F};

  // (col + 1) mod 54 or mod 40 by reciprocal multiply
  function automatic logic [7:0] col_wrap(input logic [7:0] col, input logic wide);
    logic [8:0]  v;
    logic [15:0] p;
    logic [2:0]  q;
    logic [8:0]  w;
    logic [11:0] qw;
    logic [8:0]  r;
    v  = {1'b0, col} + 9'd1;
    p  = 16'(v) * 16'(wide ? RECIP_WIDE : RECIP_NARROW);
    q  = p[15:13];
    w  = wide ? WIDE_WRAP : NARROW_WRAP;
    qw = 12'(q) * 12'(w);
    r  = v - qw[8:0];
    return r[7:0];
  endfunction

endpackage

@@ hw/rtl/indexed_lcd_controller_with_vram_top.sv @@
// top level of the indexed-register lcd controller with display memory
// a result is registered in stage one (ram read) and then in the output register
// throughput: one request per cycle via the single ram port pair, unless out_tready stalls
// reset: registers and pipeline cleared at once, palette set to its initial values, then a
// clearing pass zeroes display memory one byte a cycle with in_tready held low
`include "indexed_lcd_controller_with_vram_top_macros.svh"
module indexed_lcd_controller_with_vram_top #(
  parameter int unsigned VRAM_DEPTH = ilcd_pkg::VRAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // value[7:0], pixel_col[15:8], pixel_row[22:16], zero fill
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // pixel_level[7:0], write_dropped[8], zero fill
);

  localparam int unsigned AW = $clog2(VRAM_DEPTH);

  // request fields
  logic [1:0] kind;
  logic [7:0] value;
  logic [7:0] pcol;
  logic [6:0] prow;
  logic       in_acc;

  assign kind   = in_tuser;
  assign value  = in_tdata[7:0];
  assign pcol   = in_tdata[15:8];
  assign prow   = in_tdata[22:16];
  assign in_acc = in_tvalid && in_tready;

  // register file
  logic [7:0]    sel_r;
  logic [7:0]    ctrl1_r;
  logic [7:0]    ctrl2_r;
  logic [7:0]    wcol_r;
  logic [7:0]    wrow_r;
  ilcd_pkg::pal_t pal_r;

  // clearing pass after reset
  logic          clear_busy_r;
  logic [AW-1:0] clr_cnt_r;

  // stage one: waiting on the ram read
  logic       s1_valid_r;
  logic       s1_live_r;
  logic [1:0] s1_sub_r;
  logic       s1_palmode_r;
  logic       s1_drop_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_level_r;
  logic       out_drop_r;

  logic s1_adv;
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !clear_busy_r && (!s1_valid_r || s1_adv);

  // memory-port write: address column + row*40, dropped beyond the limit
  logic [ilcd_pkg::VADDR_W-1:0] wr_addr;
  logic                         wr_drop;
  logic                         is_mem_wr;

  assign wr_addr   = ilcd_pkg::VADDR_W'(wcol_r)
                   + ilcd_pkg::VADDR_W'(wrow_r) * ilcd_pkg::LINE_BYTES;
  assign wr_drop   = wr_addr > ilcd_pkg::MEM_LIMIT;
  assign is_mem_wr = in_acc && (kind == ilcd_pkg::KIND_DATA) && (sel_r == ilcd_pkg::REG_MEM);

  // pixel query address, with optional vertical flip
  logic                         q_off;
  logic                         q_oor;
  logic [6:0]                   src_row;
  logic [ilcd_pkg::VADDR_W-1:0] q_addr;
  logic                         q_live;

  assign q_off   = ctrl1_r[5] || !ctrl1_r[6];
  assign q_oor   = (pcol > ilcd_pkg::COL_MAX) || (prow > ilcd_pkg::ROW_MAX);
  assign src_row = ctrl1_r[0] ? (ilcd_pkg::ROW_MAX - prow) : prow;
  assign q_addr  = ilcd_pkg::VADDR_W'(pcol[7:2])
                 + ilcd_pkg::VADDR_W'(src_row) * ilcd_pkg::LINE_BYTES;
  assign q_live  = (kind == ilcd_pkg::KIND_QUERY) && !q_off && !q_oor;

  // display memory
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign ram_we    = clear_busy_r || (is_mem_wr && !wr_drop);
  assign ram_waddr = clear_busy_r ? clr_cnt_r : wr_addr[AW-1:0];
  assign ram_wdata = clear_busy_r ? 8'h00 : value;

  ilcd_ram #(
    .WIDTH(8),
    .DEPTH(VRAM_DEPTH)
  ) u_vram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_acc && q_live),
    .raddr(q_addr[AW-1:0]),
    .rdata(ram_rdata)
  );

  // register file and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r        <= '0;
      ctrl1_r      <= '0;
      ctrl2_r      <= '0;
      wcol_r       <= '0;
      wrow_r       <= '0;
      pal_r        <= ilcd_pkg::PAL_INIT;
      clear_busy_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      if (clear_busy_r) begin
        if (clr_cnt_r == AW'(VRAM_DEPTH - 1)) begin
          clear_busy_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
        end
      end
      if (in_acc) begin
        case (kind)
          ilcd_pkg::KIND_INDEX: begin
            sel_r <= value;
          end
          ilcd_pkg::KIND_DATA: begin
            case (sel_r)
              ilcd_pkg::REG_CTRL1: ctrl1_r <= value;
              ilcd_pkg::REG_CTRL2: ctrl2_r <= value;
              ilcd_pkg::REG_WCOL:  wcol_r  <= value;
              ilcd_pkg::REG_WROW:  wrow_r  <= value;
              ilcd_pkg::REG_MEM: begin
                // the cursor moves even when the store is dropped
                if (ctrl2_r[1]) begin
                  wcol_r <= ilcd_pkg::col_wrap(wcol_r, ctrl2_r[5]);
                end else begin
                  wrow_r <= wrow_r + 8'd1;
                end
              end
              ilcd_pkg::REG_PAL0,
              ilcd_pkg::REG_PAL1,
              ilcd_pkg::REG_PAL2,
              ilcd_pkg::REG_PAL3: pal_r[sel_r[1:0]] <= value;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  // stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage one payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_live_r    <= q_live;
      s1_sub_r     <= pcol[1:0];
      s1_palmode_r <= ctrl2_r[4];
      s1_drop_r    <= is_mem_wr && wr_drop;
    end
  end

  // pixel decode: leftmost pixel in the top bits of the byte
  logic [1:0] pix;
  logic [7:0] gray;
  logic [7:0] level;

  always_comb begin
    case (s1_sub_r)
      2'd0:    pix = ram_rdata[7:6];
      2'd1:    pix = ram_rdata[5:4];
      2'd2:    pix = ram_rdata[3:2];
      default: pix = ram_rdata[1:0];
    endcase
    if (s1_palmode_r) begin
      gray = {pal_r[pix][4:0], 3'b000};
    end else begin
      gray = 8'(8'(pix) * ilcd_pkg::GRAY_STEP);
    end
    level = s1_live_r ? (ilcd_pkg::FULL - gray) : 8'h00;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_level_r <= level;
      out_drop_r  <= s1_drop_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_drop_r, out_level_r};

  // no request is taken while memory is being cleared
  `ILCD_ASSERT_IMP(a_no_accept_in_clear, clear_busy_r, !in_tready)
  // once cleared, the clearing pass never restarts
  `ILCD_ASSERT_NEXT(a_clear_stays_done, !clear_busy_r, !clear_busy_r)
  // an accepted request always lands in stage one
  `ILCD_ASSERT_NEXT(a_accept_fills_s1, in_tvalid && in_tready, s1_valid_r)
  // a dropped write is never a pixel answer
  `ILCD_ASSERT_IMP(a_drop_no_level, out_tvalid && out_tdata[8], out_tdata[7:0] == 8'h00)

endmodule

@@ hw/rtl/ilcd_ram.sv @@
// generic single write port ram with registered read
module ilcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/sv/indexed_lcd_controller_with_vram_top_tb.sv @@
// self-checking testbench for the indexed-register lcd controller with display memory
`timescale 1ns / 100ps

class lcd_answer_book;
  typedef struct {
    logic [7:0] level;
    logic       dropped;
  } answer_t;

  localparam int VRAM_BYTES  = ilcd_pkg::VRAM_DEPTH_DEF;
  localparam int STORE_LIMIT = 4000;
  localparam int LINE_LEN    = 40;
  localparam int WIDE_WRAP   = 54;
  localparam int NARROW_WRAP = 40;
  localparam int GRAY_STEP   = 85;

  answer_t    awaited[$];
  int         n_errors;
  logic [7:0] sel_reg;
  logic [7:0] ctrl_one;
  logic [7:0] ctrl_two;
  logic [7:0] wr_col;
  logic [7:0] wr_row;
  logic [7:0] pal[4];
  logic [7:0] vram[VRAM_BYTES];

  function new();
    sel_reg  = '0;
    ctrl_one = '0;
    ctrl_two = '0;
    wr_col   = '0;
    wr_row   = '0;
    pal      = '{8'h00, 8'h0B, 8'h17, 8'h1F};
    foreach (vram[i]) vram[i] = '0;
    n_errors = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  // memory-port write, then column or row advance even when dropped
  function logic store_byte(logic [7:0] v);
    int   addr;
    logic drop;
    addr = int'(wr_col) + int'(wr_row) * LINE_LEN;
    drop = (addr > STORE_LIMIT) || (addr >= VRAM_BYTES);
    if (!drop) vram[addr] = v;
    if (ctrl_two[1])
      wr_col = 8'((int'(wr_col) + 1) % (ctrl_two[5] ? WIDE_WRAP : NARROW_WRAP));
    else
      wr_row = wr_row + 8'd1;
    return drop;
  endfunction

  function logic [7:0] pixel_answer(logic [7:0] col, logic [6:0] row);
    int         src;
    int         addr;
    int         sh;
    logic [7:0] b;
    logic [1:0] idx;
    logic [7:0] gray;
    if (ctrl_one[5] || !ctrl_one[6]) return 8'h00;
    if (col > 8'd159 || row > 7'd99) return 8'h00;
    src  = ctrl_one[0] ? 99 - int'(row) : int'(row);
    addr = int'(col) / 4 + src * LINE_LEN;
    if (addr >= VRAM_BYTES) return 8'h00;
    b    = vram[addr];
    sh   = 6 - 2 * int'(col[1:0]);
    idx  = 2'((b >> sh) & 8'd3);
    gray = ctrl_two[4] ? {pal[idx][4:0], 3'b000} : 8'(int'(idx) * GRAY_STEP);
    return 8'hFF - gray;
  endfunction

  // update the shadow state for one accepted request and queue its answer
  function void note_request(logic [1:0] kind, logic [7:0] value,
                             logic [7:0] col, logic [6:0] row);
    answer_t a;
    a.level   = '0;
    a.dropped = 1'b0;
    case (kind)
      ilcd_pkg::KIND_INDEX: sel_reg = value;
      ilcd_pkg::KIND_DATA: begin
        case (sel_reg)
          ilcd_pkg::REG_CTRL1: ctrl_one = value;
          ilcd_pkg::REG_CTRL2: ctrl_two = value;
          ilcd_pkg::REG_WCOL:  wr_col = value;
          ilcd_pkg::REG_WROW:  wr_row = value;
          ilcd_pkg::REG_MEM:   a.dropped = store_byte(value);
          ilcd_pkg::REG_PAL0, ilcd_pkg::REG_PAL1,
          ilcd_pkg::REG_PAL2, ilcd_pkg::REG_PAL3: pal[sel_reg[1:0]] = value;
          default: ;
        endcase
      end
      ilcd_pkg::KIND_QUERY: a.level = pixel_answer(col, row);
      default: ;
    endcase
    awaited.push_back(a);
  endfunction

  task check_answer(logic [15:0] word);
    answer_t a;
    if (awaited.size() == 0) begin
      report($sformatf("result %h with nothing awaited", word));
      return;
    end
    a = awaited.pop_front();
    if (word[7:0] !== a.level)
      report($sformatf("pixel_level %h, expected %h", word[7:0], a.level));
    if (word[8] !== a.dropped)
      report($sformatf("write_dropped %b, expected %b", word[8], a.dropped));
  endtask
endclass

module indexed_lcd_controller_with_vram_top_tb;

  // kind with no meaning; the block answers all zero
  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  // register indexes that select nothing
  localparam logic [7:0] REG_UNUSED_LO = 8'd5;
  localparam logic [7:0] REG_UNUSED_HI = 8'd255;

  localparam int N_ITEMS     = 1950;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_NS  = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // value[7:0], pixel_col[15:8], pixel_row[22:16], zero fill
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // pixel_level[7:0], write_dropped[8], zero fill

  lcd_answer_book book;
  int n_items;
  int idle_pct;
  int stall_pct;
  bit hold_req;

  indexed_lcd_controller_with_vram_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one request from a falling edge and hold it until accepted
  task automatic send(logic [1:0] kind, logic [7:0] value, logic [7:0] col,
                      logic [6:0] row);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, row, col, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_request(kind, value, col, row);
    if (kind != KIND_UNUSED) n_items++;
    @(negedge clk);
  endtask

  // index write then data write, with random filler in the pixel fields
  task automatic wr_reg(logic [7:0] idx, logic [7:0] v);
    send(ilcd_pkg::KIND_INDEX, idx, 8'($urandom_range(255)), 7'($urandom_range(127)));
    send(ilcd_pkg::KIND_DATA, v, 8'($urandom_range(255)), 7'($urandom_range(127)));
  endtask

  task automatic query(logic [7:0] col, logic [6:0] row);
    send(ilcd_pkg::KIND_QUERY, 8'($urandom_range(255)), col, row);
  endtask

  task automatic mem_burst();
    logic [7:0] v;
    if ($urandom_range(9) < 7) begin
      // mostly inside the visible area so that queries see the data
      if ($urandom_range(9) == 0) wr_reg(ilcd_pkg::REG_WROW, 8'($urandom_range(255)));
      else wr_reg(ilcd_pkg::REG_WROW, 8'($urandom_range(99)));
      wr_reg(ilcd_pkg::REG_WCOL, 8'($urandom_range(39)));
    end
    send(ilcd_pkg::KIND_INDEX, ilcd_pkg::REG_MEM, 8'($urandom_range(255)),
         7'($urandom_range(127)));
    repeat ($urandom_range(12, 1)) begin
      v = 8'($urandom_range(255));
      send(ilcd_pkg::KIND_DATA, v, 8'($urandom_range(255)), 7'($urandom_range(127)));
    end
  endtask

  task automatic query_burst();
    repeat ($urandom_range(8, 1)) begin
      if ($urandom_range(9) != 0) query(8'($urandom_range(159)), 7'($urandom_range(99)));
      else query(8'($urandom_range(255)), 7'($urandom_range(127)));
    end
  endtask

  task automatic random_step();
    int         pick;
    logic [7:0] v;
    pick = $urandom_range(99);
    v    = 8'($urandom_range(255));
    if (pick < 30) begin
      mem_burst();
    end else if (pick < 62) begin
      query_burst();
    end else if (pick < 72) begin
      // keep the display on and out of standby most of the time
      if ($urandom_range(9) < 8) begin
        v[6] = 1'b1;
        v[5] = 1'b0;
      end
      wr_reg(ilcd_pkg::REG_CTRL1, v);
    end else if (pick < 81) begin
      wr_reg(ilcd_pkg::REG_CTRL2, v);
    end else if (pick < 88) begin
      wr_reg(8'(ilcd_pkg::REG_PAL0 + $urandom_range(3)), v);
    end else if (pick < 94) begin
      wr_reg($urandom_range(1) ? ilcd_pkg::REG_WCOL : ilcd_pkg::REG_WROW, v);
    end else begin
      // noise: any kind, any index, any field
      send(2'($urandom_range(3)), v, 8'($urandom_range(255)), 7'($urandom_range(127)));
    end
  endtask

  // receiver: random stalls, plus a long hold-off counted here on request
  initial begin
    int hold_left;
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) book.check_answer(out_tdata);
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int phase;
    int new_phase;
    bit hold_done;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    n_items   = 0;
    phase     = 0;
    book      = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part; display starts off, so the first query answers zero
    query(8'd0, 7'd0);
    wr_reg(ilcd_pkg::REG_CTRL1, 8'h40);
    wr_reg(ilcd_pkg::REG_CTRL2, 8'h02);              // column advance, narrow wrap
    send(ilcd_pkg::KIND_INDEX, ilcd_pkg::REG_MEM, 8'hFF, 7'h7F);
    send(ilcd_pkg::KIND_DATA, 8'hE4, 8'h00, 7'h00);  // four pixels 3,2,1,0 at address 0
    send(ilcd_pkg::KIND_DATA, 8'h1B, 8'hFF, 7'h7F);
    query(8'd0, 7'd0);
    query(8'd1, 7'd0);
    query(8'd2, 7'd0);
    query(8'd3, 7'd0);
    wr_reg(ilcd_pkg::REG_PAL3, 8'hFF);               // shift truncates to 8 bits
    wr_reg(ilcd_pkg::REG_CTRL2, 8'h32);              // palette gray, wide wrap
    query(8'd0, 7'd0);
    wr_reg(ilcd_pkg::REG_CTRL1, 8'h41);              // vertical flip
    query(8'd4, 7'd99);
    query(8'd160, 7'd0);                   // out of range column
    query(8'd255, 7'd127);                 // out of range both
    query(8'd0, 7'd100);                   // out of range row
    send(KIND_UNUSED, 8'hFF, 8'hFF, 7'h7F);
    wr_reg(REG_UNUSED_LO, 8'h77);          // unused index, ignored
    wr_reg(REG_UNUSED_HI, 8'h88);
    wr_reg(ilcd_pkg::REG_WROW, 8'd100);
    wr_reg(ilcd_pkg::REG_WCOL, 8'd0);
    send(ilcd_pkg::KIND_INDEX, ilcd_pkg::REG_MEM, 8'h00, 7'h00);
    send(ilcd_pkg::KIND_DATA, 8'hAA, 8'h00, 7'h00);  // address at the limit, stored
    send(ilcd_pkg::KIND_DATA, 8'h55, 8'h00, 7'h00);  // one past the limit, dropped
    wr_reg(ilcd_pkg::REG_CTRL2, 8'h00);              // row advance
    wr_reg(ilcd_pkg::REG_WROW, 8'd255);
    wr_reg(ilcd_pkg::REG_WCOL, 8'd255);
    send(ilcd_pkg::KIND_INDEX, ilcd_pkg::REG_MEM, 8'h00, 7'h00);
    send(ilcd_pkg::KIND_DATA, 8'h0F, 8'h00, 7'h00);  // dropped, row wraps to zero
    wr_reg(ilcd_pkg::REG_CTRL1, 8'h60);              // standby
    query(8'd0, 7'd0);

    // random part, in idling phases
    while (n_items < N_ITEMS) begin
      new_phase = n_items * 4 / N_ITEMS;
      if (new_phase != phase) begin
        phase = new_phase;
        case (phase)
          1: begin
            idle_pct  = 59;
            stall_pct = 0;
          end
          2: begin
            // let the block drain completely before going on
            in_tvalid <= 1'b0;
            @(negedge clk);
            while (book.pending() > 0) @(negedge clk);
            idle_pct  = 0;
            stall_pct = 59;
          end
          default: begin
            idle_pct  = 17;
            stall_pct = 17;
          end
        endcase
      end
      if (!hold_done && n_items >= 300) begin
        // long receiver hold-off while requests keep coming
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      random_step();
    end

    in_tvalid <= 1'b0;
    while (book.pending() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (book.n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", book.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ilcd_pkg.sv
hw/rtl/ilcd_ram.sv
hw/rtl/indexed_lcd_controller_with_vram_top.sv
tb/sv/indexed_lcd_controller_with_vram_top_tb.sv
